/* hw/rtl/rfd_pkg.sv */
package rfd_pkg;

    // frame length byte limits and data byte count
    localparam logic [7:0] LEN_MIN    = 8'd3;
    localparam logic [7:0] LEN_MAX    = 8'd5;
    localparam logic [1:0] DATA_BYTES = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_SYNC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LOWEST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_HIGHEST  = 3'd4;

    // parser phases; codes 6 and 7 act like idle
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_SYNC3   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] first_sync;
        logic [7:0] second_sync;
        logic [7:0] third_sync;
        logic [7:0] id_lowest;
        logic [7:0] id_highest;
    } t_cfg;

    typedef struct packed {
        logic [7:0] device_id;
        logic [2:0] length_code;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [7:0] check_byte;
    } t_frame;

endpackage

/* hw/rtl/rfd_cfg_regs.sv */
module rfd_cfg_regs
    import rfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // register file, writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_sync  <= 8'd255;
            r_cfg.second_sync <= 8'd255;
            r_cfg.third_sync  <= 8'd161;
            r_cfg.id_lowest   <= 8'd1;
            r_cfg.id_highest  <= 8'd254;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_SYNC:  r_cfg.first_sync  <= i_cfg_data;
                CFG_SECOND_SYNC: r_cfg.second_sync <= i_cfg_data;
                CFG_THIRD_SYNC:  r_cfg.third_sync  <= i_cfg_data;
                CFG_ID_LOWEST:   r_cfg.id_lowest   <= i_cfg_data;
                CFG_ID_HIGHEST:  r_cfg.id_highest  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/rfd_parser.sv */
module rfd_parser
    import rfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_hit,
    output t_frame     o_frame
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_id, n_id;
    logic [2:0] r_len, n_len;
    logic [7:0] r_data0, n_data0;
    logic [7:0] r_data1, n_data1;
    logic [1:0] r_seen, n_seen;

    logic id_ok;
    logic len_ok;
    logic data_more;

    assign id_ok     = (i_rx_byte >= i_cfg.id_lowest) && (i_rx_byte <= i_cfg.id_highest);
    assign len_ok    = (i_rx_byte >= LEN_MIN) && (i_rx_byte <= LEN_MAX);
    assign data_more = r_seen < DATA_BYTES;

    // next phase
    always_comb begin
        n_phase = PH_IDLE;
        unique case (r_phase)
            PH_SYNC2: begin
                if (i_rx_byte == i_cfg.second_sync) begin
                    n_phase = PH_SYNC3;
                end else if (i_rx_byte == i_cfg.first_sync) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC3:   if (i_rx_byte == i_cfg.third_sync) n_phase = PH_ID;
            PH_ID:      if (id_ok) n_phase = PH_LEN;
            PH_LEN:     if (len_ok) n_phase = PH_PAYLOAD;
            PH_PAYLOAD: if (data_more) n_phase = PH_PAYLOAD;
            default:    if (i_rx_byte == i_cfg.first_sync) n_phase = PH_SYNC2;
        endcase
    end

    // datapath updates and frame match
    always_comb begin
        n_sum   = r_sum;
        n_id    = r_id;
        n_len   = r_len;
        n_data0 = r_data0;
        n_data1 = r_data1;
        n_seen  = 2'd0;
        o_hit   = 1'b0;
        unique case (r_phase)
            PH_SYNC3: if (i_rx_byte == i_cfg.third_sync) n_sum = i_rx_byte;
            PH_ID: begin
                if (id_ok) begin
                    n_id  = i_rx_byte;
                    n_sum = r_sum + i_rx_byte;
                    n_seen = r_seen;
                end
            end
            PH_LEN: begin
                if (len_ok) begin
                    n_len = i_rx_byte[2:0];
                    n_sum = r_sum + i_rx_byte;
                end
            end
            PH_PAYLOAD: begin
                if (data_more) begin
                    if (r_seen[0]) n_data1 = i_rx_byte;
                    else           n_data0 = i_rx_byte;
                    n_sum  = r_sum + i_rx_byte;
                    n_seen = r_seen + 2'd1;
                end else begin
                    o_hit = (~r_sum == i_rx_byte);
                end
            end
            default: ;
        endcase
    end

    // parser state, advances once per taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seen  <= 2'd0;
            r_sum   <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 3'd0;
            r_data0 <= 8'd0;
            r_data1 <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_id    <= n_id;
            r_len   <= n_len;
            r_data0 <= n_data0;
            r_data1 <= n_data1;
        end
    end

    assign o_frame.device_id   = r_id;
    assign o_frame.length_code = r_len;
    assign o_frame.data_first  = r_data0;
    assign o_frame.data_second = r_data1;
    assign o_frame.check_byte  = i_rx_byte;

endmodule

/* hw/rtl/rfd_out_stage.sv */
module rfd_out_stage
    import rfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_frame i_frame,
    input  logic   i_res_ready,
    output logic   o_free,
    output logic   o_res_valid,
    output t_frame o_frame
);

    logic   r_valid;
    t_frame r_frame;

    // slot can take a new word when empty or being drained this cycle
    assign o_free = !r_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

    assign o_res_valid = r_valid;
    assign o_frame     = r_frame;

endmodule

/* hw/rtl/reply_frame_deframer_unit.sv */
// Reply frame deframer.
// Input channel: one received byte per word on i_rx_byte, handshake
// i_rx_valid / o_rx_ready. Output channel: one word per good frame on
// o_device_id, o_length_code, o_data_first, o_data_second, o_check_byte,
// handshake o_res_valid / i_res_ready.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 first sync, 1 second sync, 2 third sync, 3 lowest id, 4 highest id).
// Throughput: one byte per cycle while o_rx_ready is high. The parser state
// and running sum update in the cycle a byte is taken; a check byte that
// matches loads the result register at that edge, so the frame word is
// valid in the next cycle. Frames with any error produce nothing.
// Stall: while a result waits and i_res_ready is low, o_rx_ready drops
// until the word is taken; a taken word frees the slot in the same cycle.
// Reset: synchronous, active low; parser returns to waiting for the first
// header, configuration returns to its defaults, the result slot empties.
module reply_frame_deframer_unit
    import rfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [7:0]           o_device_id,
    output logic [2:0]           o_length_code,
    output logic [7:0]           o_data_first,
    output logic [7:0]           o_data_second,
    output logic [7:0]           o_check_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg   cfg;
    t_frame parsed;
    t_frame result;
    logic   step;
    logic   hit;
    logic   slot_free;

    assign o_rx_ready = slot_free;
    assign step       = i_rx_valid && slot_free;

    rfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_hit     (hit),
        .o_frame   (parsed)
    );

    rfd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && hit),
        .i_frame     (parsed),
        .i_res_ready (i_res_ready),
        .o_free      (slot_free),
        .o_res_valid (o_res_valid),
        .o_frame     (result)
    );

    assign o_device_id   = result.device_id;
    assign o_length_code = result.length_code;
    assign o_data_first  = result.data_first;
    assign o_data_second = result.data_second;
    assign o_check_byte  = result.check_byte;

`ifndef SYNTHESIS
    // a matched check byte shows up as the result word next cycle
    a_hit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && hit) |=> (o_res_valid && (o_check_byte == $past(i_rx_byte))))
        else $error("matched frame not delivered");

    // any emitted length lies in the legal range
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && hit) |=> ((o_length_code >= 3'd3) && (o_length_code <= 3'd5)))
        else $error("result length out of range");

    // a taken word with no new match leaves the slot empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && !(step && hit)) |=> !o_res_valid)
        else $error("result word repeated");

    // reset empties the result slot
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");
`endif

endmodule

/* sim/reply_frame_deframer_unit_tb.sv */
module reply_frame_deframer_unit_tb;
    import rfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // how a generated frame is damaged, if at all
    typedef enum {
        FK_GOOD,
        FK_RESTART,
        FK_BAD_SYNC2,
        FK_BAD_SYNC3,
        FK_BAD_ID,
        FK_BAD_LEN,
        FK_BAD_CHECK,
        FK_SHORT
    } t_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_rx_valid = 1'b0;
    logic                 o_rx_ready;
    logic [7:0]           i_rx_byte = 8'h00;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic [7:0]           o_device_id;
    logic [2:0]           o_length_code;
    logic [7:0]           o_data_first;
    logic [7:0]           o_data_second;
    logic [7:0]           o_check_byte;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = 8'h00;

    // parser copy: configuration and state
    t_cfg       cfg;
    t_phase     pars_phase;
    logic [7:0] sum_acc;
    logic [7:0] frame_id;
    logic [2:0] frame_len;
    logic [7:0] frame_data [2];
    logic [1:0] data_count;

    // frames still owed by the block, oldest first
    t_frame     owed_frames [$];
    t_frame     got_frame;

    int errors = 0;
    int bytes_sent = 0;
    int frames_seen = 0;
    int configs_used = 0;

    // sender pacing
    int burst_left = 0;
    int gap_max = 4;

    // receiver pacing
    int rx_cycle = 0;
    int hold_request = 0;
    int hold_left = 0;

    reply_frame_deframer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_device_id   (o_device_id),
        .o_length_code (o_length_code),
        .o_data_first  (o_data_first),
        .o_data_second (o_data_second),
        .o_check_byte  (o_check_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // parser step for one accepted byte
    task automatic advance_parser(input logic [7:0] b);
        case (pars_phase)
            PH_SYNC2: begin
                if (b == cfg.second_sync) begin
                    pars_phase = PH_SYNC3;
                end else if (b == cfg.first_sync) begin
                    pars_phase = PH_SYNC2;
                    data_count = 2'd0;
                end else begin
                    pars_phase = PH_IDLE;
                    data_count = 2'd0;
                end
            end
            PH_SYNC3: begin
                if (b == cfg.third_sync) begin
                    sum_acc = b;
                    pars_phase = PH_ID;
                end else begin
                    pars_phase = PH_IDLE;
                    data_count = 2'd0;
                end
            end
            PH_ID: begin
                if (b >= cfg.id_lowest && b <= cfg.id_highest) begin
                    frame_id = b;
                    sum_acc = sum_acc + b;
                    pars_phase = PH_LEN;
                end else begin
                    pars_phase = PH_IDLE;
                    data_count = 2'd0;
                end
            end
            PH_LEN: begin
                if (b >= LEN_MIN && b <= LEN_MAX) begin
                    frame_len = b[2:0];
                    sum_acc = sum_acc + b;
                    data_count = 2'd0;
                    pars_phase = PH_PAYLOAD;
                end else begin
                    pars_phase = PH_IDLE;
                    data_count = 2'd0;
                end
            end
            PH_PAYLOAD: begin
                if (data_count < DATA_BYTES) begin
                    frame_data[data_count[0]] = b;
                    sum_acc = sum_acc + b;
                    data_count = data_count + 2'd1;
                end else begin
                    // check byte closes the frame either way
                    if (~sum_acc == b)
                        owed_frames.push_back('{frame_id, frame_len, frame_data[0],
                                                frame_data[1], b});
                    pars_phase = PH_IDLE;
                    data_count = 2'd0;
                end
            end
            default: begin
                if (b == cfg.first_sync) begin
                    pars_phase = PH_SYNC2;
                end else begin
                    pars_phase = PH_IDLE;
                end
                data_count = 2'd0;
            end
        endcase
    endtask

    // offer one byte, bursts with random gaps, return once it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        advance_parser(b);
        bytes_sent++;
    endtask

    // stop offering and wait until every owed frame has come out
    task automatic drain_frames();
        i_rx_valid <= 1'b0;
        burst_left = 0;
        while (owed_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FIRST_SYNC:  cfg.first_sync  = val;
            CFG_SECOND_SYNC: cfg.second_sync = val;
            CFG_THIRD_SYNC:  cfg.third_sync  = val;
            CFG_ID_LOWEST:   cfg.id_lowest   = val;
            CFG_ID_HIGHEST:  cfg.id_highest  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] f, s, t, lo, hi);
        drain_frames();
        write_reg(CFG_FIRST_SYNC, f);
        write_reg(CFG_SECOND_SYNC, s);
        write_reg(CFG_THIRD_SYNC, t);
        write_reg(CFG_ID_LOWEST, lo);
        write_reg(CFG_ID_HIGHEST, hi);
        configs_used++;
    endtask

    // build one frame under the current settings, damaged as kind says
    task automatic send_frame(input t_kind kind, input logic [7:0] id, len, d0, d1);
        logic [7:0] fbytes [$];
        logic [7:0] chk;
        int keep;
        if (kind == FK_BAD_ID) begin
            if (cfg.id_lowest > 8'd0)
                id = 8'($urandom_range(0, cfg.id_lowest - 1));
            else if (cfg.id_highest < 8'hFF)
                id = 8'($urandom_range(cfg.id_highest + 1, 255));
        end
        if (kind == FK_BAD_LEN)
            len = 8'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(6, 255));
        chk = ~(cfg.third_sync + id + len + d0 + d1);
        if (kind == FK_BAD_CHECK)
            chk = chk ^ 8'($urandom_range(1, 255));

        fbytes.push_back(cfg.first_sync);
        if (kind == FK_RESTART)
            repeat ($urandom_range(1, 3)) fbytes.push_back(cfg.first_sync);
        fbytes.push_back(kind == FK_BAD_SYNC2 ?
                         cfg.second_sync ^ 8'($urandom_range(1, 255)) : cfg.second_sync);
        fbytes.push_back(kind == FK_BAD_SYNC3 ?
                         cfg.third_sync ^ 8'($urandom_range(1, 255)) : cfg.third_sync);
        fbytes.push_back(id);
        fbytes.push_back(len);
        fbytes.push_back(d0);
        fbytes.push_back(d1);
        fbytes.push_back(chk);
        if (kind == FK_SHORT) begin
            keep = $urandom_range(1, 7);
            while (fbytes.size() > keep) void'(fbytes.pop_back());
        end
        foreach (fbytes[k]) send_byte(fbytes[k]);
    endtask

    // mostly good frames with random content, the rest restarted or damaged frames and noise
    task automatic test_random_frames(input int n_frames);
        int pick;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] d0;
        logic [7:0] d1;
        for (int n = 0; n < n_frames; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       id = cfg.id_lowest;
                1:       id = cfg.id_highest;
                default: id = 8'($urandom_range(cfg.id_lowest, cfg.id_highest));
            endcase
            len = 8'($urandom_range(3, 5));
            d0  = 8'($urandom);
            d1  = 8'($urandom);
            if (pick < 62)
                send_frame(FK_GOOD, id, len, d0, d1);
            else if (pick < 68)
                send_frame(FK_RESTART, id, len, d0, d1);
            else if (pick < 72)
                send_frame(FK_BAD_SYNC2, id, len, d0, d1);
            else if (pick < 76)
                send_frame(FK_BAD_SYNC3, id, len, d0, d1);
            else if (pick < 81)
                send_frame(FK_BAD_ID, id, len, d0, d1);
            else if (pick < 86)
                send_frame(FK_BAD_LEN, id, len, d0, d1);
            else if (pick < 92)
                send_frame(FK_BAD_CHECK, id, len, d0, d1);
            else if (pick < 96)
                send_frame(FK_SHORT, id, len, d0, d1);
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // reset settings: id range ends, check byte 00 and FF, data 00 and FF
    task automatic test_default_frames();
        send_frame(FK_GOOD, 8'd1, 8'd3, 8'h5A, 8'h00);
        send_frame(FK_GOOD, 8'd254, 8'd5, 8'h5C, 8'h00);
        send_frame(FK_GOOD, 8'h80, 8'd4, 8'hFF, 8'hFF);
        send_frame(FK_BAD_CHECK, 8'h42, 8'd4, 8'h13, 8'h37);
    endtask

    // first header while waiting for second restarts; a failed byte is not
    // looked at again as a first header
    task automatic test_header_restart();
        set_config(8'hAA, 8'h55, 8'h3C, 8'd10, 8'd20);
        send_frame(FK_RESTART, 8'd15, 8'd3, 8'h01, 8'h02);
        send_byte(cfg.first_sync);
        send_byte(cfg.second_sync);
        send_frame(FK_GOOD, 8'd12, 8'd4, 8'h00, 8'hFF);
        send_frame(FK_GOOD, 8'd20, 8'd5, 8'h7F, 8'h80);
    endtask

    // full id range, single id range and empty id range
    task automatic test_id_range_edges();
        set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_frame(FK_GOOD, 8'h00, 8'd3, 8'hA5, 8'h5A);
        send_frame(FK_GOOD, 8'hFF, 8'd5, 8'h00, 8'h00);
        test_random_frames(30);
        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(FK_GOOD, 8'hFF, 8'd4, 8'hFF, 8'hFF);
        test_random_frames(30);
        set_config(8'h3A, 8'hC5, 8'h99, 8'h81, 8'h80);
        send_frame(FK_GOOD, 8'h80, 8'd4, 8'h11, 8'h22);
        send_frame(FK_GOOD, 8'h81, 8'd4, 8'h11, 8'h22);
        test_random_frames(30);
    endtask

    // hold the output off long enough that the block stops taking bytes
    task automatic test_backpressure();
        gap_max = 0;
        hold_request = 300;
        repeat (12) send_frame(FK_GOOD, 8'($urandom_range(cfg.id_lowest, cfg.id_highest)),
                               8'($urandom_range(3, 5)), 8'($urandom), 8'($urandom));
        gap_max = 4;
    endtask

    // receiver: long hold-off on request, otherwise a rotating stall pattern
    always @(posedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       i_res_ready <= 1'b1;
                1:       i_res_ready <= ($urandom_range(0, 1) == 1);
                2:       i_res_ready <= ($urandom_range(0, 3) != 0);
                default: i_res_ready <= ((rx_cycle % 7) > 2);
            endcase
        end
    end

    function automatic void compare_field(input string fname, input logic [7:0] want,
                                          input logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, fname, want, seen);
            errors++;
        end
    endfunction

    // every taken frame word against the oldest owed frame
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            frames_seen++;
            if (owed_frames.size() == 0) begin
                $display("%0t: unexpected frame word, expected none, %s %02h %0d %02h %02h %02h",
                         $time, "actual", o_device_id, o_length_code, o_data_first,
                         o_data_second, o_check_byte);
                errors++;
            end else begin
                got_frame = owed_frames.pop_front();
                compare_field("device_id", got_frame.device_id, o_device_id);
                compare_field("length_code", 8'(got_frame.length_code), 8'(o_length_code));
                compare_field("data_first", got_frame.data_first, o_data_first);
                compare_field("data_second", got_frame.data_second, o_data_second);
                compare_field("check_byte", got_frame.check_byte, o_check_byte);
            end
        end
    end

    initial begin
        #5ms;
        $display("%0t: timeout, %0d frames still owed", $time, owed_frames.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        cfg = '{8'hFF, 8'hFF, 8'hA1, 8'd1, 8'd254};
        pars_phase = PH_IDLE;
        sum_acc = 8'h00;
        frame_id = 8'h00;
        frame_len = 3'd0;
        frame_data[0] = 8'h00;
        frame_data[1] = 8'h00;
        data_count = 2'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_frames();
        test_random_frames(40);
        test_header_restart();
        test_random_frames(50);
        test_backpressure();
        test_id_range_edges();
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 100)),
                   8'($urandom_range(100, 255)));
        gap_max = 0;
        test_random_frames(20);
        gap_max = 4;
        test_random_frames(25);

        drain_frames();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d bytes across %0d settings, checked %0d frame words,",
                 bytes_sent, configs_used + 1, frames_seen);
        $display("including restarts, damaged frames, noise and a long output stall.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
